>>> hdl/double_ended_queue_with_search_unit_macros.svh
// ---------------------------------------------------------------------------
// Deque assertion macros
// Shared assertion forms for the deque block; clk and arst_n are taken from
// the scope of the module that uses them.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_UNIT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define DQS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define DQS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/dqs_pkg.sv
// ---------------------------------------------------------------------------
// Deque package
// Sizes, action and status codes, and the scan control struct.
// ---------------------------------------------------------------------------
package dqs_pkg;

	// ring depth, power of two so slot arithmetic wraps by truncation
	localparam int DEPTH   = 256;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int OCC_W   = 9;
	localparam int ACT_W   = 3;
	localparam int STAT_W  = 2;
	localparam int OUT_DW  = 56;

	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_COUNT      = 3'd4;
	localparam logic [ACT_W-1:0] ACT_FIND       = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic clr;
		logic en;
	} scan_ctrl_t;

endpackage

>>> hdl/dqs_scan.sv
// ---------------------------------------------------------------------------
// Deque scan unit
// Shared comparator: compares one stored word per cycle against the key and
// accumulates the match count and the found flag.
// ---------------------------------------------------------------------------
module dqs_scan import dqs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  scan_ctrl_t        ctrl,
	input  logic [DATA_W-1:0] rd_data,
	input  logic [DATA_W-1:0] key,
	output logic [CNT_W-1:0]  match_count,
	output logic              found
);

	logic [CNT_W-1:0] match_q;
	logic             found_q;
	logic             hit;

	assign hit = (rd_data == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
			found_q <= 1'b0;
		end else if (ctrl.clr) begin
			match_q <= '0;
			found_q <= 1'b0;
		end else if (ctrl.en && hit) begin
			match_q <= match_q + CNT_W'(1);
			found_q <= 1'b1;
		end
	end

	assign match_count = match_q;
	assign found       = found_q;

endmodule

>>> hdl/double_ended_queue_with_search_unit.sv
// ---------------------------------------------------------------------------
// Double-ended queue with search
// Path to result valid: pushes, failed pops and unused actions pass through DONE;
//   pops through POP, then DONE; count and find through SCAN, then DONE.
// Throughput: one word in flight; tready returns the cycle after the result is
//   loaded, and a result held by the receiver holds off the input.
// Reset clears head pointer, entry count and handshakes; stored words are not
//   cleared and need no clearing pass.
// ---------------------------------------------------------------------------
`include "double_ended_queue_with_search_unit_macros.svh"

module double_ended_queue_with_search_unit import dqs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [31:0]       s_axis_tdata,  // value[31:0]
	input  logic [2:0]        s_axis_tuser,  // action[2:0]
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// popped_value[31:0], occupancy[40:32], match_count[49:41], found[50], zero[55:51]
	output logic [OUT_DW-1:0] m_axis_tdata,
	output logic [1:0]        m_axis_tuser   // status[1:0]
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   head_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    idx_q;
	logic [ACT_W-1:0]    act_q;
	logic [DATA_W-1:0]   value_q;
	logic [DATA_W-1:0]   popped_q;
	logic [STAT_W-1:0]   status_q;
	logic                rd_vld_s1;
	logic                m_valid_q;
	logic [OUT_DW-1:0]   m_tdata_q;
	logic [STAT_W-1:0]   m_tuser_q;

	logic [DATA_W-1:0]   mem [DEPTH];
	logic [DATA_W-1:0]   rdata_q;

	logic                accept;
	logic                full;
	logic                empty;
	logic                out_free;
	logic [CNT_W-1:0]    cnt_m1;
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [ADDR_W-1:0]   raddr;
	scan_ctrl_t          scan_ctrl;
	logic [CNT_W-1:0]    scan_count;
	logic                scan_found;
	logic [OCC_W-1:0]    res_match;
	logic                res_found;
	logic                push_act;
	logic                pop_act;
	logic                push_full;
	logic                pop_ok;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign full          = (count_q == CNT_W'(DEPTH));
	assign empty         = (count_q == '0);
	assign cnt_m1        = count_q - CNT_W'(1);
	assign out_free      = !m_valid_q || m_axis_tready;

	assign push_act  = (s_axis_tuser == ACT_PUSH_FRONT) || (s_axis_tuser == ACT_PUSH_BACK);
	assign pop_act   = (s_axis_tuser == ACT_POP_FRONT) || (s_axis_tuser == ACT_POP_BACK);
	assign push_full = accept && full && push_act;
	assign pop_ok    = accept && !empty && pop_act;

	always_comb begin
		we              = 1'b0;
		waddr           = head_q - ADDR_W'(1);
		raddr           = head_q + idx_q[ADDR_W-1:0];
		scan_ctrl.clr   = accept;
		scan_ctrl.en    = rd_vld_s1;
		if (state_q == S_IDLE) begin
			raddr = (s_axis_tuser == ACT_POP_FRONT) ? head_q : head_q + cnt_m1[ADDR_W-1:0];
		end
		if (accept && !full) begin
			if (s_axis_tuser == ACT_PUSH_FRONT) begin
				we = 1'b1;
			end else if (s_axis_tuser == ACT_PUSH_BACK) begin
				we    = 1'b1;
				waddr = head_q + count_q[ADDR_W-1:0];
			end
		end
	end

	// ring storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= s_axis_tdata;
		end
		rdata_q <= mem[raddr];
	end

	dqs_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (scan_ctrl),
		.rd_data     (rdata_q),
		.key         (value_q),
		.match_count (scan_count),
		.found       (scan_found)
	);

	assign res_match = (act_q == ACT_COUNT) ? OCC_W'(scan_count) : '0;
	assign res_found = (act_q == ACT_FIND) && scan_found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			act_q     <= '0;
			value_q   <= '0;
			popped_q  <= '0;
			status_q  <= ST_OK;
			rd_vld_s1 <= 1'b0;
			m_valid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= ST_OK;
		end else begin
			if (state_q == S_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q    <= s_axis_tuser;
						value_q  <= s_axis_tdata;
						popped_q <= '0;
						status_q <= ST_OK;
						idx_q    <= '0;
						state_q  <= S_DONE;
						case (s_axis_tuser)
							ACT_PUSH_FRONT: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									head_q  <= head_q - ADDR_W'(1);
									count_q <= count_q + CNT_W'(1);
								end
							end
							ACT_PUSH_BACK: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							ACT_POP_FRONT: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									head_q  <= head_q + ADDR_W'(1);
									count_q <= cnt_m1;
									state_q <= S_POP;
								end
							end
							ACT_POP_BACK: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									count_q <= cnt_m1;
									state_q <= S_POP;
								end
							end
							ACT_COUNT, ACT_FIND: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_POP: begin
					popped_q <= rdata_q;
					state_q  <= S_DONE;
				end
				S_SCAN: begin
					// read issued at idx, compared in the following cycle
					rd_vld_s1 <= (idx_q < count_q);
					if (idx_q < count_q) begin
						idx_q <= idx_q + CNT_W'(1);
					end else if (!rd_vld_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_tdata_q <= {5'd0, res_found, res_match, OCC_W'(count_q), popped_q};
						m_tuser_q <= status_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

	`DQS_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`DQS_ASSERT_SAME(a_scan_idx, state_q == S_SCAN, idx_q <= count_q, "scan index past count")
	`DQS_ASSERT_NEXT(a_push_full, push_full, status_q == ST_FULL, "full push not flagged")
	`DQS_ASSERT_NEXT(a_push_keep, push_full, $stable(count_q) && $stable(head_q), "state moved")
	`DQS_ASSERT_NEXT(a_pop_dec, pop_ok, count_q == $past(cnt_m1) && state_q == S_POP, "bad pop")

endmodule
